// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tslca_pkg.sv =====
package tslca_pkg;

    localparam int ID_W    = 6;
    localparam int LVL_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int ENTRY_W = 7;
    localparam int PC_W    = 5;

    localparam logic [SIZE_W-1:0]  TREE_SIZE_RST = 7'd64;
    localparam logic [ENTRY_W-1:0] ROOT_ENTRY    = 7'h40;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TREE  = 2'd2;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] node_id;
        logic [ID_W-1:0] parent_id;
        logic            is_root;
        logic            last;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]  ancestor_id;
        logic [LVL_W-1:0] hops;
        logic [1:0]       status;
    } t_rsp;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CUR_NODE,
        OP_CUR_ANC,
        OP_WALK,
        OP_SAVE_B,
        OP_SAVE_A,
        OP_LIFT_A,
        OP_LIFT_B,
        OP_FOLD,
        OP_FIRST,
        OP_ERR1,
        OP_ERR2,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        RS_CUR,
        RS_A,
        RS_B
    } t_rsel;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_STATUS_NZ,
        C_NODE_BAD,
        C_ROOT,
        C_WALK_OK,
        C_FIRST,
        C_NOT_A_DEEPER,
        C_NOT_B_DEEPER,
        C_A_EQ_B,
        C_ALVL_ZERO
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_rsel           rsel;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic status_nz;
        logic node_bad;
        logic root;
        logic walk_ok;
        logic first;
        logic a_deeper;
        logic b_deeper;
        logic a_eq_b;
        logic alvl_zero;
    } t_flags;

    // program labels
    localparam logic [PC_W-1:0] PC_ENTRY  = 5'd0;
    localparam logic [PC_W-1:0] PC_WALK_N = 5'd3;
    localparam logic [PC_W-1:0] PC_SAVE_B = 5'd7;
    localparam logic [PC_W-1:0] PC_WALK_A = 5'd9;
    localparam logic [PC_W-1:0] PC_SAVE_A = 5'd13;
    localparam logic [PC_W-1:0] PC_LIFT_A = 5'd14;
    localparam logic [PC_W-1:0] PC_LIFT_B = 5'd16;
    localparam logic [PC_W-1:0] PC_JOINT  = 5'd18;
    localparam logic [PC_W-1:0] PC_FOLD   = 5'd22;
    localparam logic [PC_W-1:0] PC_FIRST  = 5'd23;
    localparam logic [PC_W-1:0] PC_ERR1   = 5'd24;
    localparam logic [PC_W-1:0] PC_ERR2   = 5'd25;
    localparam logic [PC_W-1:0] PC_END    = 5'd26;

    function automatic t_uword mk(t_op op, t_rsel rs, t_cond c, logic [PC_W-1:0] tg);
        t_uword w;
        w.op     = op;
        w.rsel   = rs;
        w.cond   = c;
        w.target = tg;
        return w;
    endfunction

    // Fold one member: depth of member, depth of running ancestor (a first
    // member just takes its own), level both, then lift together until they meet.
    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = mk(OP_NOP,      RS_CUR, C_STATUS_NZ,    PC_END);
            5'd1:  w = mk(OP_NOP,      RS_CUR, C_NODE_BAD,     PC_ERR1);
            5'd2:  w = mk(OP_CUR_NODE, RS_CUR, C_NEVER,        PC_ENTRY);
            5'd3:  w = mk(OP_NOP,      RS_CUR, C_NEVER,        PC_ENTRY);
            5'd4:  w = mk(OP_WALK,     RS_CUR, C_ROOT,         PC_SAVE_B);
            5'd5:  w = mk(OP_NOP,      RS_CUR, C_WALK_OK,      PC_WALK_N);
            5'd6:  w = mk(OP_NOP,      RS_CUR, C_ALWAYS,       PC_ERR2);
            5'd7:  w = mk(OP_SAVE_B,   RS_CUR, C_FIRST,        PC_FIRST);
            5'd8:  w = mk(OP_CUR_ANC,  RS_CUR, C_NEVER,        PC_ENTRY);
            5'd9:  w = mk(OP_NOP,      RS_CUR, C_NEVER,        PC_ENTRY);
            5'd10: w = mk(OP_WALK,     RS_CUR, C_ROOT,         PC_SAVE_A);
            5'd11: w = mk(OP_NOP,      RS_CUR, C_WALK_OK,      PC_WALK_A);
            5'd12: w = mk(OP_NOP,      RS_CUR, C_ALWAYS,       PC_ERR2);
            5'd13: w = mk(OP_SAVE_A,   RS_CUR, C_NEVER,        PC_ENTRY);
            5'd14: w = mk(OP_NOP,      RS_A,   C_NOT_A_DEEPER, PC_LIFT_B);
            5'd15: w = mk(OP_LIFT_A,   RS_A,   C_ALWAYS,       PC_LIFT_A);
            5'd16: w = mk(OP_NOP,      RS_B,   C_NOT_B_DEEPER, PC_JOINT);
            5'd17: w = mk(OP_LIFT_B,   RS_B,   C_ALWAYS,       PC_LIFT_B);
            5'd18: w = mk(OP_NOP,      RS_A,   C_A_EQ_B,       PC_FOLD);
            5'd19: w = mk(OP_NOP,      RS_A,   C_ALVL_ZERO,    PC_ERR2);
            5'd20: w = mk(OP_LIFT_A,   RS_B,   C_NEVER,        PC_ENTRY);
            5'd21: w = mk(OP_LIFT_B,   RS_B,   C_ALWAYS,       PC_JOINT);
            5'd22: w = mk(OP_FOLD,     RS_CUR, C_ALWAYS,       PC_END);
            5'd23: w = mk(OP_FIRST,    RS_CUR, C_ALWAYS,       PC_END);
            5'd24: w = mk(OP_ERR1,     RS_CUR, C_ALWAYS,       PC_END);
            5'd25: w = mk(OP_ERR2,     RS_CUR, C_ALWAYS,       PC_END);
            default: w = mk(OP_END,    RS_CUR, C_NEVER,        PC_ENTRY);
        endcase
        return w;
    endfunction

endpackage

// ===== src/tslca_table.sv =====
module tslca_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [AW-1:0]                   i_waddr,
    input  logic [tslca_pkg::ENTRY_W-1:0]   i_wdata,
    input  logic [AW-1:0]                   i_raddr,
    output logic [tslca_pkg::ENTRY_W-1:0]   o_rdata
);

    logic [tslca_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [tslca_pkg::ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tslca_seq.sv =====
module tslca_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tslca_pkg::t_flags i_flags,
    output tslca_pkg::t_uword o_uw,
    output logic              o_busy
);

    logic [tslca_pkg::PC_W-1:0] r_pc, n_pc;
    logic                       r_run, n_run;
    tslca_pkg::t_uword          rom_word;
    logic                       take;

    assign rom_word = tslca_pkg::ucode(r_pc);

    always_comb begin
        case (rom_word.cond)
            tslca_pkg::C_NEVER:        take = 1'b0;
            tslca_pkg::C_ALWAYS:       take = 1'b1;
            tslca_pkg::C_STATUS_NZ:    take = i_flags.status_nz;
            tslca_pkg::C_NODE_BAD:     take = i_flags.node_bad;
            tslca_pkg::C_ROOT:         take = i_flags.root;
            tslca_pkg::C_WALK_OK:      take = i_flags.walk_ok;
            tslca_pkg::C_FIRST:        take = i_flags.first;
            tslca_pkg::C_NOT_A_DEEPER: take = !i_flags.a_deeper;
            tslca_pkg::C_NOT_B_DEEPER: take = !i_flags.b_deeper;
            tslca_pkg::C_A_EQ_B:       take = i_flags.a_eq_b;
            tslca_pkg::C_ALVL_ZERO:    take = i_flags.alvl_zero;
            default:                   take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc  = r_pc;
        n_run = r_run;
        if (i_start) begin
            n_run = 1'b1;
            n_pc  = tslca_pkg::PC_ENTRY;
        end else if (r_run) begin
            if (rom_word.op == tslca_pkg::OP_END) begin
                n_run = 1'b0;
            end
            n_pc = take ? rom_word.target : r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= tslca_pkg::PC_ENTRY;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
        end
    end

    // idle: datapath sees a no-op
    assign o_uw   = r_run ? rom_word
                          : tslca_pkg::mk(tslca_pkg::OP_NOP, tslca_pkg::RS_CUR,
                                          tslca_pkg::C_NEVER, tslca_pkg::PC_ENTRY);
    assign o_busy = r_run;

endmodule

// ===== src/tslca_dp.sv =====
module tslca_dp #(
    parameter int MAX_NODES = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  tslca_pkg::t_req                  i_req,
    input  logic [tslca_pkg::SIZE_W-1:0]     i_tree_size,
    input  tslca_pkg::t_uword                i_uw,
    input  logic [tslca_pkg::ENTRY_W-1:0]    i_rdata,
    output logic [tslca_pkg::ID_W-1:0]       o_raddr,
    output tslca_pkg::t_flags                o_flags,
    output tslca_pkg::t_rsp                  o_rsp,
    output logic                             o_done
);

    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int IW = tslca_pkg::ID_W;
    localparam int LW = tslca_pkg::LVL_W;

    logic [IW-1:0] r_node, n_node, r_cur, n_cur, r_a, n_a, r_b, n_b;
    logic [IW-1:0] r_anc, n_anc;
    logic [LW-1:0] r_alvl, n_alvl, r_blvl, n_blvl, r_lvl, n_lvl;
    logic [LW-1:0] r_max, n_max, r_anc_lvl, n_anc_lvl;
    logic [SW-1:0] r_steps, n_steps;
    logic [1:0]    r_status, n_status;
    logic          r_last, n_last, r_first, n_first, r_open, n_open;
    logic          r_done, n_done;
    tslca_pkg::t_rsp r_rsp, n_rsp;

    logic [IW-1:0] rd_parent;
    logic          rd_root;

    function automatic logic id_ok(logic [IW-1:0] id, logic [tslca_pkg::SIZE_W-1:0] size);
        return (tslca_pkg::SIZE_W'(id) < size) && (int'(id) < MAX_NODES);
    endfunction

    assign rd_parent = i_rdata[IW-1:0];
    assign rd_root   = i_rdata[tslca_pkg::ENTRY_W-1];

    always_comb begin
        case (i_uw.rsel)
            tslca_pkg::RS_CUR: o_raddr = r_cur;
            tslca_pkg::RS_A:   o_raddr = r_a;
            tslca_pkg::RS_B:   o_raddr = r_b;
            default:           o_raddr = r_cur;
        endcase
    end

    always_comb begin
        o_flags.status_nz = (r_status != tslca_pkg::ST_OK);
        o_flags.node_bad  = !id_ok(r_node, i_tree_size);
        o_flags.root      = rd_root;
        o_flags.walk_ok   = id_ok(r_cur, i_tree_size) && (int'(r_steps) < MAX_NODES);
        o_flags.first     = r_first;
        o_flags.a_deeper  = (r_alvl > r_blvl);
        o_flags.b_deeper  = (r_blvl > r_alvl);
        o_flags.a_eq_b    = (r_a == r_b);
        o_flags.alvl_zero = (r_alvl == '0);
    end

    always_comb begin
        n_node    = r_node;
        n_last    = r_last;
        n_first   = r_first;
        n_open    = r_open;
        n_status  = r_status;
        n_anc     = r_anc;
        n_max     = r_max;
        n_anc_lvl = r_anc_lvl;
        n_lvl     = r_lvl;
        n_cur     = r_cur;
        n_steps   = r_steps;
        n_a       = r_a;
        n_b       = r_b;
        n_alvl    = r_alvl;
        n_blvl    = r_blvl;
        n_rsp     = r_rsp;
        n_done    = 1'b0;

        if (i_start) begin
            n_node  = i_req.node_id;
            n_last  = i_req.last;
            n_first = !r_open;
            if (!r_open) begin
                n_open   = 1'b1;
                n_status = tslca_pkg::ST_OK;
                n_anc    = '0;
                n_max    = '0;
            end
        end

        case (i_uw.op)
            tslca_pkg::OP_CUR_NODE: begin
                n_cur   = r_node;
                n_steps = '0;
            end
            tslca_pkg::OP_CUR_ANC: begin
                n_cur   = r_anc;
                n_steps = '0;
            end
            tslca_pkg::OP_WALK: begin
                if (!rd_root) begin
                    n_cur   = rd_parent;
                    n_steps = r_steps + 1'b1;
                end
            end
            tslca_pkg::OP_SAVE_B: begin
                // a successful walk stays below 64 hops
                n_b    = r_node;
                n_blvl = LW'(r_steps);
                n_lvl  = LW'(r_steps);
            end
            tslca_pkg::OP_SAVE_A: begin
                n_a    = r_anc;
                n_alvl = LW'(r_steps);
            end
            tslca_pkg::OP_LIFT_A: begin
                n_a    = rd_parent;
                n_alvl = r_alvl - 1'b1;
            end
            tslca_pkg::OP_LIFT_B: begin
                n_b    = rd_parent;
                n_blvl = r_blvl - 1'b1;
            end
            tslca_pkg::OP_FOLD: begin
                n_anc     = r_a;
                n_anc_lvl = r_alvl;
                if (r_lvl > r_max) begin
                    n_max = r_lvl;
                end
            end
            tslca_pkg::OP_FIRST: begin
                n_anc     = r_node;
                n_max     = r_lvl;
                n_anc_lvl = r_lvl;
            end
            tslca_pkg::OP_ERR1: n_status = tslca_pkg::ST_RANGE;
            tslca_pkg::OP_ERR2: n_status = tslca_pkg::ST_TREE;
            tslca_pkg::OP_END: begin
                if (r_last) begin
                    n_done = 1'b1;
                    n_open = 1'b0;
                    if (r_status == tslca_pkg::ST_OK) begin
                        n_rsp.ancestor_id = r_anc;
                        n_rsp.hops        = r_max - r_anc_lvl;
                    end else begin
                        n_rsp.ancestor_id = '0;
                        n_rsp.hops        = '0;
                    end
                    n_rsp.status = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_done   <= 1'b0;
            r_status <= tslca_pkg::ST_OK;
        end else begin
            r_open   <= n_open;
            r_done   <= n_done;
            r_status <= n_status;
        end
        r_node    <= n_node;
        r_last    <= n_last;
        r_first   <= n_first;
        r_anc     <= n_anc;
        r_max     <= n_max;
        r_anc_lvl <= n_anc_lvl;
        r_lvl     <= n_lvl;
        r_cur     <= n_cur;
        r_steps   <= n_steps;
        r_a       <= n_a;
        r_b       <= n_b;
        r_alvl    <= n_alvl;
        r_blvl    <= n_blvl;
        r_rsp     <= n_rsp;
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_done;

endmodule

// ===== src/tree_set_lowest_common_ancestor_unit.sv =====
// Lowest common ancestor over a parent-pointer tree. A write item (start with
// busy low) stores one node's parent or root mark and never raises busy. A
// query item raises busy while a small microprogram folds the member into the
// running ancestor; every parent hop is one read of the parent table's
// registered read port, so the time is set by tree depth: a depth walk for the
// member, then one for the running ancestor, a climb to level the deeper node,
// then lifting both until they meet (a first member of a set only walks its
// own depth). A member whose set already failed skips all walks. On the last
// member of a set the result shows on o_rsp with o_done for exactly one cycle,
// starting at the edge that drops busy; it cannot be held off, so the receiver
// must take it then. The table has no reset: every node a walk can reach must
// be written first.
module tree_set_lowest_common_ancestor_unit #(
    parameter int MAX_NODES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tslca_pkg::t_req              i_req,
    input  logic                         i_cfg_we,
    input  logic [tslca_pkg::SIZE_W-1:0] i_cfg_wdata,
    output tslca_pkg::t_rsp              o_rsp,
    output logic                         o_done
);

    // ids are 6 bits wide, so no more than 64 entries are addressable
    localparam int ID_SPAN   = 1 << tslca_pkg::ID_W;
    localparam int TBL_DEPTH = (MAX_NODES < ID_SPAN) ? MAX_NODES : ID_SPAN;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    logic [tslca_pkg::SIZE_W-1:0]  r_tree_size;
    logic                          accept, wr_en, q_start;
    logic [tslca_pkg::ENTRY_W-1:0] wr_entry, rd_entry;
    logic [tslca_pkg::ID_W-1:0]    rd_addr;
    tslca_pkg::t_uword             uw;
    tslca_pkg::t_flags             flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_size <= tslca_pkg::TREE_SIZE_RST;
        end else if (i_cfg_we) begin
            r_tree_size <= i_cfg_wdata;
        end
    end

    assign accept   = start && !busy;
    assign wr_en    = accept && (i_req.req_type == tslca_pkg::REQ_WRITE)
                      && (int'(i_req.node_id) < MAX_NODES);
    assign q_start  = accept && (i_req.req_type == tslca_pkg::REQ_QUERY);
    assign wr_entry = i_req.is_root ? tslca_pkg::ROOT_ENTRY
                                    : {1'b0, i_req.parent_id};

    tslca_table #(
        .DEPTH (TBL_DEPTH),
        .AW    (TBL_AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_req.node_id[TBL_AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr[TBL_AW-1:0]),
        .o_rdata (rd_entry)
    );

    tslca_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_flags (flags),
        .o_uw    (uw),
        .o_busy  (busy)
    );

    tslca_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (q_start),
        .i_req       (i_req),
        .i_tree_size (r_tree_size),
        .i_uw        (uw),
        .i_rdata     (rd_entry),
        .o_raddr     (rd_addr),
        .o_flags     (flags),
        .o_rsp       (o_rsp),
        .o_done      (o_done)
    );

endmodule

// ===== src/tslca_checker.sv =====
`include "assert_macros.svh"

module tslca_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input tslca_pkg::t_req i_req,
    input tslca_pkg::t_rsp o_rsp,
    input logic            o_done
);

    // a result follows the end of a query's busy period
    `CHK_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $fell(busy), "result without busy end")

    // a table write never raises busy
    `CHK_NEXT(a_write_no_busy, i_clk, i_rst_n, start && !busy && i_req.req_type == tslca_pkg::REQ_WRITE, !busy, "write raised busy")

    `CHK_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_req.req_type == tslca_pkg::REQ_QUERY, busy, "query did not raise busy")

    // failed sets report zero ancestor and hops
    `CHK_NOW(a_err_zero, i_clk, i_rst_n, o_done && o_rsp.status != tslca_pkg::ST_OK, o_rsp.ancestor_id == '0 && o_rsp.hops == '0, "error result not cleared")

endmodule

bind tree_set_lowest_common_ancestor_unit tslca_checker u_chk (.*);

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tslca_pkg::*;

    localparam int MAX_NODES     = 64;
    localparam int ITEM_TARGET   = 2000;
    localparam int IDLE_STOP     = 1700;
    localparam int SETTLE_CYCLES = 64;
    localparam int PRINT_CAP     = 200;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_wdata;
    t_rsp              o_rsp;
    logic              o_done;

    tree_set_lowest_common_ancestor_unit #(
        .MAX_NODES(MAX_NODES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_rsp      (o_rsp),
        .o_done     (o_done)
    );

    // shadow copy of the block state
    logic [ENTRY_W-1:0] parent_tab [MAX_NODES];
    logic [SIZE_W-1:0]  tree_size_q;
    logic [ID_W-1:0]    anc_q;
    logic [LVL_W-1:0]   max_lvl_q;
    bit                 set_open_q;
    logic [1:0]         set_status_q;

    t_rsp lca_expected [$];
    t_rsp lca_want;
    int   error_count;
    int   items_sent;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic note_error(input string msg);
        if (error_count < PRINT_CAP) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        error_count++;
    endtask

    function automatic bit id_in_use(input int id);
        return id < int'(tree_size_q) && id < MAX_NODES;
    endfunction

    function automatic int parent_of(input int id);
        return int'(parent_tab[id][ID_W-1:0]);
    endfunction

    // climb to the root; fails on an out-of-range node or parent, or a runaway walk
    function automatic bit walk_to_root(input int id, output int lvl);
        int cur;
        int steps;
        cur   = id;
        steps = 0;
        lvl   = 0;
        if (!id_in_use(cur)) return 1'b0;
        while (!parent_tab[cur][ENTRY_W-1]) begin
            cur = parent_of(cur);
            if (!id_in_use(cur)) return 1'b0;
            steps++;
            if (steps >= MAX_NODES) return 1'b0;
        end
        lvl = steps;
        return 1'b1;
    endfunction

    function automatic void fold_member(input t_req r);
        int   lvl;
        int   a;
        int   b;
        int   alvl;
        int   blvl;
        int   anc_lvl;
        bit   first;
        t_rsp res;
        anc_lvl = 0;
        lvl     = 0;
        alvl    = 0;
        if (r.req_type == REQ_WRITE) begin
            parent_tab[r.node_id] = r.is_root ? ROOT_ENTRY : {1'b0, r.parent_id};
            return;
        end
        first = !set_open_q;
        if (first) begin
            set_open_q   = 1'b1;
            set_status_q = ST_OK;
            anc_q        = '0;
            max_lvl_q    = '0;
        end
        if (set_status_q == ST_OK) begin
            if (!id_in_use(r.node_id)) begin
                set_status_q = ST_RANGE;
            end else if (!walk_to_root(r.node_id, lvl)) begin
                set_status_q = ST_TREE;
            end else if (first) begin
                anc_q     = r.node_id;
                max_lvl_q = LVL_W'(lvl);
                anc_lvl   = lvl;
            end else begin
                a    = anc_q;
                b    = r.node_id;
                blvl = lvl;
                if (!walk_to_root(a, alvl)) begin
                    set_status_q = ST_TREE;
                end else begin
                    while (alvl > blvl) begin
                        a = parent_of(a);
                        alvl--;
                    end
                    while (blvl > alvl) begin
                        b = parent_of(b);
                        blvl--;
                    end
                    while (a != b) begin
                        if (alvl == 0) begin
                            set_status_q = ST_TREE;
                            break;
                        end
                        a = parent_of(a);
                        b = parent_of(b);
                        alvl--;
                    end
                    if (set_status_q == ST_OK) begin
                        anc_q   = ID_W'(a);
                        anc_lvl = alvl;
                        if (lvl > int'(max_lvl_q)) max_lvl_q = LVL_W'(lvl);
                    end
                end
            end
        end
        if (!r.last) return;
        set_open_q = 1'b0;
        if (set_status_q == ST_OK) begin
            res.ancestor_id = anc_q;
            res.hops        = LVL_W'(int'(max_lvl_q) - anc_lvl);
        end else begin
            res.ancestor_id = '0;
            res.hops        = '0;
        end
        res.status = set_status_q;
        lca_expected.insert(lca_expected.size(), res);
    endfunction

    function automatic t_req wr_item(input int node, input int par, input bit root);
        t_req r;
        r.req_type  = REQ_WRITE;
        r.node_id   = ID_W'(node);
        r.parent_id = ID_W'(par);
        r.is_root   = root;
        r.last      = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // parent_id and is_root are don't-care on queries, so they get noise
    function automatic t_req q_item(input int node, input bit last);
        t_req r;
        r.req_type  = REQ_QUERY;
        r.node_id   = ID_W'(node);
        r.parent_id = ID_W'($urandom_range(0, 63));
        r.is_root   = 1'($urandom_range(0, 1));
        r.last      = last;
        return r;
    endfunction

    // one transfer, then an optional idle burst
    task automatic send_item(input t_req r);
        int gap;
        @(negedge i_clk);
        start = 1'b1;
        i_req = r;
        while (busy !== 1'b0) @(negedge i_clk);
        @(posedge i_clk);
        fold_member(r);
        items_sent++;
        if (items_sent < IDLE_STOP && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (lca_expected.size() != 0) @(negedge i_clk);
    endtask

    task automatic wait_for_idle();
        wait_results_drained();
        while (busy !== 1'b0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tree_size(input logic [SIZE_W-1:0] v);
        wait_for_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(posedge i_clk);
        tree_size_q = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (lca_expected.size() == 0) begin
                note_error($sformatf("result with nothing pending: %p", o_rsp));
            end else begin
                lca_want = lca_expected.pop_front();
                if (o_rsp.ancestor_id !== lca_want.ancestor_id)
                    note_error($sformatf("ancestor_id got %0d want %0d",
                                         o_rsp.ancestor_id, lca_want.ancestor_id));
                if (o_rsp.hops !== lca_want.hops)
                    note_error($sformatf("hops got %0d want %0d",
                                         o_rsp.hops, lca_want.hops));
                if (o_rsp.status !== lca_want.status)
                    note_error($sformatf("status got %0d want %0d",
                                         o_rsp.status, lca_want.status));
            end
        end
    end

    // node i hangs off i-1, so depth equals id
    task automatic test_chain_load();
        send_item(wr_item(0, 63, 1'b1));
        for (int i = 1; i < MAX_NODES; i++) begin
            send_item(wr_item(i, i - 1, 1'b0));
        end
    endtask

    task automatic test_depth_extremes();
        send_item(q_item(63, 1'b1));
        send_item(q_item(63, 1'b0));
        send_item(q_item(0, 1'b1));
        send_item(q_item(0, 1'b0));
        send_item(q_item(0, 1'b1));
    endtask

    task automatic test_branch_ancestor();
        send_item(wr_item(40, 20, 1'b0));
        send_item(q_item(40, 1'b0));
        send_item(q_item(30, 1'b1));
        send_item(q_item(30, 1'b0));
        send_item(q_item(45, 1'b0));
        send_item(q_item(35, 1'b1));
    endtask

    task automatic test_forest_cycle_sticky();
        // second root: members in different trees
        send_item(wr_item(50, 0, 1'b1));
        send_item(q_item(50, 1'b0));
        send_item(q_item(10, 1'b0));
        send_item(q_item(5, 1'b1));
        // two-node loop
        send_item(wr_item(60, 61, 1'b0));
        send_item(wr_item(61, 60, 1'b0));
        send_item(q_item(62, 1'b1));
        send_item(q_item(62, 1'b0));
        send_item(q_item(3, 1'b1));
        send_item(wr_item(60, 59, 1'b0));
        send_item(wr_item(61, 60, 1'b0));
        send_item(wr_item(50, 49, 1'b0));
    endtask

    task automatic test_write_inside_set();
        send_item(q_item(12, 1'b0));
        send_item(wr_item(11, 2, 1'b0));
        send_item(q_item(25, 1'b1));
        send_item(wr_item(11, 10, 1'b0));
    endtask

    task automatic test_tree_size_bounds();
        write_tree_size(7'd0);
        send_item(q_item(5, 1'b1));
        send_item(q_item(0, 1'b1));
        write_tree_size(7'd1);
        send_item(q_item(0, 1'b1));
        send_item(q_item(1, 1'b1));
        write_tree_size(7'd16);
        // entry above the bound is kept, but a walk into it fails
        send_item(wr_item(20, 3, 1'b0));
        send_item(wr_item(15, 20, 1'b0));
        send_item(q_item(15, 1'b1));
        send_item(q_item(14, 1'b0));
        send_item(q_item(16, 1'b1));
        write_tree_size(7'd127);
        send_item(q_item(15, 1'b0));
        send_item(q_item(63, 1'b1));
        write_tree_size(TREE_SIZE_RST);
        send_item(q_item(20, 1'b1));
    endtask

    task automatic load_random_tree(input int reach, input int root_odds);
        int lo;
        send_item(wr_item(0, $urandom_range(0, 63), 1'b1));
        for (int i = 1; i < MAX_NODES; i++) begin
            if (root_odds != 0 && $urandom_range(0, root_odds - 1) == 0) begin
                send_item(wr_item(i, $urandom_range(0, 63), 1'b1));
            end else begin
                lo = (i > reach) ? i - reach : 0;
                send_item(wr_item(i, $urandom_range(i - 1, lo), 1'b0));
            end
        end
    endtask

    task automatic send_random_write();
        int node;
        if ($urandom_range(0, 3) == 0) begin
            // may break the tree: loops, far parents, extra roots
            send_item(wr_item($urandom_range(0, 63), $urandom_range(0, 63),
                              1'($urandom_range(0, 1))));
        end else begin
            node = $urandom_range(1, 63);
            send_item(wr_item(node, $urandom_range(node - 1, 0), 1'b0));
        end
    endtask

    task automatic run_random_set(input int bound);
        int n;
        int node;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) send_random_write();
            if (bound == 0 || $urandom_range(0, 15) == 0) node = $urandom_range(0, 63);
            else node = $urandom_range(bound - 1, 0);
            send_item(q_item(node, k == n - 1));
        end
    endtask

    task automatic test_random_sets();
        logic [SIZE_W-1:0] size_pick;
        int bound;
        int reach;
        int root_odds;
        int phase_no;
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0: size_pick = 7'd1;
                1: size_pick = 7'd64;
                2: size_pick = 7'd127;
                3: size_pick = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'd2;
                default: size_pick = SIZE_W'($urandom_range(63, 3));
            endcase
            write_tree_size(size_pick);
            reach     = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 1) : MAX_NODES;
            root_odds = ($urandom_range(0, 1) == 0) ? 0 : 12;
            load_random_tree(reach, root_odds);
            bound = (int'(size_pick) > MAX_NODES) ? MAX_NODES : int'(size_pick);
            repeat ($urandom_range(40, 10)) begin
                if (items_sent >= ITEM_TARGET) break;
                run_random_set(bound);
            end
            // after the third phase, hold the sender off until all pending results are out
            if (phase_no == 2) wait_results_drained();
            phase_no++;
        end
    endtask

    initial begin
        start        = 1'b0;
        i_req        = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        error_count  = 0;
        items_sent   = 0;
        for (int i = 0; i < MAX_NODES; i++) parent_tab[i] = '0;
        tree_size_q  = TREE_SIZE_RST;
        anc_q        = '0;
        max_lvl_q    = '0;
        set_open_q   = 1'b0;
        set_status_q = ST_OK;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_chain_load();
        test_depth_extremes();
        test_branch_ancestor();
        test_forest_cycle_sticky();
        test_write_inside_set();
        test_tree_size_bounds();
        test_random_sets();

        wait_for_idle();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
